// ===== sv/lrukv_pkg.sv =====
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared sizes and types for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  // Store size and derived widths
  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int AGE_W   = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int CAP_RESET = 16;

  // Register indexes (word address)
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // One result item
  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
  } res_t;

  // One request item
  typedef struct packed {
    op_t                      op;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } req_t;

endpackage

// ===== sv/lrukv_core.sv =====
// ----------------------------------------------------------------------------
// lrukv_core
// Entry store with parallel key compare, age ranking and replacement.
// ----------------------------------------------------------------------------
module lrukv_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       proc,
  input  lrukv_pkg::req_t            req,
  input  logic [lrukv_pkg::CAP_W-1:0] capacity,
  output lrukv_pkg::res_t            res
);
  import lrukv_pkg::*;

  localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

  logic [ENTRIES-1:0]             valid_r, valid_nxt;
  logic [AGE_W-1:0]               age_r   [ENTRIES];
  logic [AGE_W-1:0]               age_nxt [ENTRIES];
  logic signed [KEY_W-1:0]        key_r   [ENTRIES];
  logic signed [KEY_W-1:0]        key_nxt [ENTRIES];
  logic signed [DATA_W-1:0]       data_r  [ENTRIES];
  logic signed [DATA_W-1:0]       data_nxt[ENTRIES];
  logic [OCC_W-1:0]               occ_r, occ_nxt;

  logic [ENTRIES-1:0] hit_vec, old_vec;
  logic [IDX_W-1:0]   hit_idx, old_idx, free_idx, slot;
  logic               hit, evict, insert;
  logic [CAP_W-1:0]   cap_eff;
  logic [AGE_W-1:0]   old_age, slot_age;

  // Compare the key and the oldest rank against every entry
  assign old_age = AGE_W'(occ_r - OCC_W'(1));
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req.key);
      old_vec[i] = valid_r[i] && (age_r[i] == old_age);
    end
  end

  // Lowest-indexed pick for hit, oldest and free slot
  always_comb begin
    hit_idx  = '0;
    old_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (old_vec[i]) begin
        old_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Decide the slot; a zero capacity acts as one
  assign hit     = |hit_vec;
  assign cap_eff = (capacity == '0) ? CAP_W'(1) : capacity;
  assign evict   = (req.op == OP_PUT) && !hit &&
                   ((CMP_W'(occ_r) >= CMP_W'(cap_eff)) || (occ_r >= OCC_W'(ENTRIES)));
  assign insert  = (req.op == OP_PUT) && !hit && !evict;
  assign slot    = hit ? hit_idx : (evict ? old_idx : free_idx);
  assign slot_age = age_r[slot];

  // Result of this item
  always_comb begin
    res.found   = hit;
    res.evicted = evict;
    if (req.op == OP_PUT) begin
      res.read_value = '0;
    end else if (hit) begin
      res.read_value = data_r[hit_idx];
    end else begin
      res.read_value = '1;
    end
  end

  // Next state: promote the slot, age the younger entries, store on put
  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i]  = age_r[i];
      key_nxt[i]  = key_r[i];
      data_nxt[i] = data_r[i];
    end
    if (proc && (hit || req.op == OP_PUT)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if ((IDX_W'(i) != slot) && valid_r[i] && (insert || (age_r[i] < slot_age))) begin
          age_nxt[i] = age_r[i] + AGE_W'(1);
        end
      end
      age_nxt[slot] = '0;
      if (req.op == OP_PUT) begin
        data_nxt[slot] = req.value;
        key_nxt[slot]  = req.key;
      end
      if (insert) begin
        valid_nxt[slot] = 1'b1;
        occ_nxt         = occ_r + OCC_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  // Payload store
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      key_r[i]  <= key_nxt[i];
      data_r[i] <= data_nxt[i];
    end
  end

endmodule

// ===== sv/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   in_op, in_key, in_value
//   out_     output     out_valid/out_stall out_found, out_read_value, out_evicted
//   APB      input      psel/penable/pready capacity register at address 0
//
// One item per cycle unless both registers are full and out_stall holds the
// result: an accepted item sits in the input register while the 16-way key
// compare and age update run on it, and the result register then presents it.
// Reset clears all valid bits and ages at once; no sweep is needed. An
// out_stall holds the result register; a new item is still taken while the
// result waits, unless both registers are full.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic signed [31:0]               in_key,
  input  logic signed [31:0]               in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic signed [31:0]               out_read_value,
  output logic                             out_evicted,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrukv_pkg::APB_AW-1:0]     paddr,
  input  logic [lrukv_pkg::APB_DW-1:0]     pwdata,
  output logic [lrukv_pkg::APB_DW-1:0]     prdata,
  output logic                             pready
);
  import lrukv_pkg::*;

  logic             s1_v_r, s1_v_nxt;
  logic             s2_v_r, s2_v_nxt;
  req_t             req_r;
  res_t             res_r, res_c;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             accept, s2_free, adv;

  // Handshake
  assign s2_free  = !s2_v_r || !out_stall;
  assign adv      = s1_v_r && s2_free;
  assign in_stall = s1_v_r && !s2_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (adv) begin
      s2_v_nxt = 1'b1;
    end else if (!out_stall) begin
      s2_v_nxt = 1'b0;
    end
  end

  // Capacity register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_r) : '0;
  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      cap_r  <= CAP_W'(CAP_RESET);
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      cap_r  <= cap_nxt;
    end
  end

  // Input and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op    <= op_t'(in_op);
      req_r.key   <= in_key;
      req_r.value <= in_value;
    end
    if (adv) begin
      res_r <= res_c;
    end
  end

  lrukv_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc     (adv),
    .req      (req_r),
    .capacity (cap_r),
    .res      (res_c)
  );

  assign out_valid      = s2_v_r;
  assign out_found      = res_r.found;
  assign out_read_value = res_r.read_value;
  assign out_evicted    = res_r.evicted;

endmodule

// ===== sv/lrukv_checker.sv =====
// ----------------------------------------------------------------------------
// lrukv_checker
// Port-level checks on the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lrukv_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_found,
  input logic signed [31:0]           out_read_value,
  input logic                         out_evicted
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value))
    else $error("stalled result item changed");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // An eviction is a put on a new key
  a_evict_put: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_found && (out_read_value == 32'sd0))
    else $error("evicting result carries found or data");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (.*);
